[sv/gb3_pkg.sv]
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 Gaussian blur: pixel and column types,
// line store entry, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

   // default line store depth, one entry per column
   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int PIXEL_W  = 8;
   localparam int COEF_W   = 16;
   localparam int CSR_W    = 16;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int ROW_W    = 12;
   localparam int FRAC_BITS = 16;

   // frame height limit
   localparam int MAX_HEIGHT = 4096;

   // four pixels summed, then weighted
   localparam int NSUM_W   = PIXEL_W + 2;
   localparam int PROD_C_W = COEF_W + PIXEL_W;
   localparam int PROD_N_W = COEF_W + NSUM_W;
   localparam int SUM_W    = PROD_N_W + 2;
   localparam int RES_W    = SUM_W - FRAC_BITS;

   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);
   localparam logic [PIXEL_W-1:0] PIXEL_MAX = '1;

   // register reset values
   localparam logic [COEF_W-1:0]   COEF_CENTER_RESET  = 16'd16384;
   localparam logic [COEF_W-1:0]   COEF_EDGE_RESET    = 16'd8192;
   localparam logic [COEF_W-1:0]   COEF_CORNER_RESET  = 16'd4096;
   localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd768;

   typedef enum logic [2:0] {
      CSR_COEF_CENTER  = 3'd0,
      CSR_COEF_EDGE    = 3'd1,
      CSR_COEF_CORNER  = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // one window column, index 0 is the oldest row
   typedef pixel_type [2:0] column_type;

   // two stored rows at one column
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_entry_type;

endpackage

`default_nettype wire

[sv/gaussian_blur_3x3.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_3x3
// Streaming 3x3 Gaussian blur with programmable Q0.16 weights.
// ----------------------------------------------------------------------------
// usage
//   pixels enter in raster order on the req_ channel (valid/ready), one
//   transaction per pixel. every interior pixel whose 3x3 window is complete
//   leaves on the rsp_ channel as one transaction; border pixels give none.
//   rsp_is_last marks the last interior pixel of a frame.
//   csr_ writes set the weights and the frame size; write only while idle.
// pipeline and throughput
//   one pixel per clock sustained while rsp_ready stays high. the line store
//   read starts at the accepting edge; window shift, weight multiply and
//   sum/round/saturate into the output register then follow as registered
//   stages. the single read port of the line store and the multiplier stage
//   set this rate.
// reset
//   counters, window and pipeline valids clear; registers return to their
//   defaults. the line store is not cleared; the first two rows fill it.
// stall
//   a low rsp_ready holds the output register; each stage moves into a free
//   slot, so bubbles collapse and req_ready drops only when all slots fill.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3 #(
   parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   // pixel input
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [gb3_pkg::PIXEL_W-1:0]    req_pixel,
   // blurred output
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [gb3_pkg::PIXEL_W-1:0]    rsp_blurred_value,
   output logic                           rsp_is_last,
   // register writes
   input  wire                            csr_write_enable,
   input  wire gb3_pkg::csr_index_type    csr_index,
   input  wire  [gb3_pkg::CSR_W-1:0]      csr_write_data
);
   import gb3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int MW_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (MW_W > WIDTH_W) ? MW_W : WIDTH_W;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [COEF_W-1:0]   coef_center_ff;
   logic [COEF_W-1:0]   coef_edge_ff;
   logic [COEF_W-1:0]   coef_corner_ff;
   logic [WIDTH_W-1:0]  image_width_ff;
   logic [HEIGHT_W-1:0] image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_center_ff  <= COEF_CENTER_RESET;
         coef_edge_ff    <= COEF_EDGE_RESET;
         coef_corner_ff  <= COEF_CORNER_RESET;
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COEF_CENTER:  coef_center_ff  <= csr_write_data[COEF_W-1:0];
            CSR_COEF_EDGE:    coef_edge_ff    <= csr_write_data[COEF_W-1:0];
            CSR_COEF_CORNER:  coef_corner_ff  <= csr_write_data[COEF_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[HEIGHT_W-1:0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // last column and last row, sizes clamped to the supported range
   // ------------------------------------------------------------------------
   logic [CMP_W-1:0] width_x;
   logic [CMP_W-1:0] col_last;
   logic [ROW_W-1:0] row_last;

   assign width_x = CMP_W'(image_width_ff);

   always_comb begin
      if (width_x < CMP_W'(3)) begin
         col_last = CMP_W'(2);
      end else if (width_x > CMP_W'(MAX_WIDTH)) begin
         col_last = CMP_W'(MAX_WIDTH - 1);
      end else begin
         col_last = width_x - CMP_W'(1);
      end
      if (image_height_ff < HEIGHT_W'(3)) begin
         row_last = ROW_W'(2);
      end else if (image_height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         row_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         row_last = ROW_W'(image_height_ff - HEIGHT_W'(1));
      end
   end

   // ------------------------------------------------------------------------
   // handshake chain, each stage fills when it is empty or moving on
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s2_ready, s3_ready, s4_ready;
   logic req_fire, s1_move;

   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign req_fire  = req_valid && req_ready;
   assign s1_move   = s1_valid_ff && s2_ready;

   // ------------------------------------------------------------------------
   // stage 0: position counters, line store read
   // ------------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             row_end, frame_end, emit;

   assign row_end   = CMP_W'(col_ff) >= col_last;
   assign frame_end = row_ff >= row_last;
   assign emit      = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: stored rows arrive, rows rotate back into the line store
   // ------------------------------------------------------------------------
   pixel_type        s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_emit_ff, s1_last_ff;
   line_entry_type   rows_rd, rows_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_ff;
         s1_emit_ff  <= emit;
         s1_last_ff  <= row_end && frame_end;
      end
   end

   assign rows_wr.older = rows_rd.newer;
   assign rows_wr.newer = s1_pixel_ff;

   gb3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (rows_rd),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (rows_wr)
   );

   // ------------------------------------------------------------------------
   // stage 2: window as a chain of column cells, newest column on the right
   // ------------------------------------------------------------------------
   column_type new_col;
   column_type win [3];
   logic       s2_last_ff;

   assign new_col[0] = rows_rd.older;
   assign new_col[1] = rows_rd.newer;
   assign new_col[2] = s1_pixel_ff;

   gb3_column_cell u_cell_right (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_move),
      .col_in   (new_col),
      .col_out  (win[2])
   );

   gb3_column_cell u_cell_mid (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_move),
      .col_in   (win[2]),
      .col_out  (win[1])
   );

   gb3_column_cell u_cell_left (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_move),
      .col_in   (win[1]),
      .col_out  (win[0])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         // border pixels stop here, they only move the window
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_last_ff <= s1_last_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: weights times centre, edge sum and corner sum
   // ------------------------------------------------------------------------
   logic [NSUM_W-1:0]   edge_sum, corner_sum;
   logic [PROD_C_W-1:0] prod_center_ff;
   logic [PROD_N_W-1:0] prod_edge_ff, prod_corner_ff;
   logic                s3_last_ff;

   assign edge_sum = NSUM_W'(win[1][0]) + NSUM_W'(win[0][1])
                   + NSUM_W'(win[2][1]) + NSUM_W'(win[1][2]);
   assign corner_sum = NSUM_W'(win[0][0]) + NSUM_W'(win[2][0])
                     + NSUM_W'(win[0][2]) + NSUM_W'(win[2][2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         prod_center_ff <= PROD_C_W'(coef_center_ff) * PROD_C_W'(win[1][1]);
         prod_edge_ff   <= PROD_N_W'(coef_edge_ff) * PROD_N_W'(edge_sum);
         prod_corner_ff <= PROD_N_W'(coef_corner_ff) * PROD_N_W'(corner_sum);
         s3_last_ff     <= s2_last_ff;
      end
   end

   // ------------------------------------------------------------------------
   // stage 4: add, round, drop the fraction, saturate
   // ------------------------------------------------------------------------
   logic [SUM_W-1:0]   total;
   logic [RES_W-1:0]   scaled;
   pixel_type          blurred;
   pixel_type          out_value_ff;
   logic               out_last_ff;

   assign total   = SUM_W'(prod_center_ff) + SUM_W'(prod_edge_ff)
                  + SUM_W'(prod_corner_ff) + ROUND_HALF;
   assign scaled  = total[SUM_W-1:FRAC_BITS];
   assign blurred = (|scaled[RES_W-1:PIXEL_W]) ? PIXEL_MAX : scaled[PIXEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         out_value_ff <= blurred;
         out_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_blurred_value = out_value_ff;
   assign rsp_is_last       = out_last_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   // a pixel waiting on the line store output keeps its data
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_pixel_ff)
                                  && $stable(s1_col_ff))
      else $error("stage 1 transaction changed while stalled");

   // the end of a frame is always an interior pixel
   a_last_is_emitted: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |-> s1_emit_ff)
      else $error("frame end marked on a border pixel");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !rsp_valid)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[sv/gb3_line_store.sv]
// ----------------------------------------------------------------------------
// gb3_line_store
// Two-row line store, one entry per column holding both rows, one write and
// one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_line_store #(
   parameter int DEPTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire                        clock,
   input  wire                        rd_en,
   input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
   output gb3_pkg::line_entry_type    rd_data,
   input  wire                        wr_en,
   input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire gb3_pkg::line_entry_type wr_data
);
   import gb3_pkg::*;

   line_entry_type mem [DEPTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/gb3_column_cell.sv]
// ----------------------------------------------------------------------------
// gb3_column_cell
// One column of the 3x3 window; takes its neighbor's column on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_column_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     shift_en,
   input  wire gb3_pkg::column_type col_in,
   output gb3_pkg::column_type     col_out
);
   import gb3_pkg::*;

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

[sim/gaussian_blur_3x3_tb.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_tb
// Self-checking bench for the streaming 3x3 Gaussian blur. Pixels stream in
// through a queue-fed driver with random gaps. A predictor with its own line
// stores, window and register copies computes each interior pixel at the
// moment its input transaction is accepted. A monitor with random
// back-pressure compares every output transaction, field by field, with the
// oldest pending prediction. Weights and frame size are rewritten between
// phases while the block is idle, including out-of-range sizes and
// mid-frame shrinks.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_tb;
   import gb3_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 8;
   localparam int RANDOM_PIXELS = 500;
   localparam int WIDE_PIXELS   = MAX_WIDTH_DEFAULT + 100;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDLE_PERCENT  = 38;
   localparam int MIN_SIZE      = 3;
   // no register sits at this index, writes to it must be dropped
   localparam logic [2:0] CSR_INDEX_UNUSED = 3'd7;

   typedef enum int {
      PIX_UNIFORM,
      PIX_EXTREME,
      PIX_SMOOTH
   } pixel_style_type;

   typedef struct {
      pixel_type value;
      logic      last;
   } blur_result_type;

   // dut ports
   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   pixel_type           req_pixel = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   pixel_type           rsp_blurred_value;
   logic                rsp_is_last;
   logic                csr_write_enable = 1'b0;
   csr_index_type       csr_index = CSR_COEF_CENTER;
   logic [CSR_W-1:0]    csr_write_data = '0;

   // stimulus and scoreboard
   pixel_type           pending_pixels [$];
   blur_result_type     expected_blurs [$];
   logic                steady_flow = 1'b0;
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;

   // predictor state: two stored rows, sliding window, raster position
   pixel_type           older_row [MAX_WIDTH_DEFAULT] = '{default: '0};
   pixel_type           newer_row [MAX_WIDTH_DEFAULT] = '{default: '0};
   pixel_type           win [3][3] = '{default: '{default: '0}};
   int unsigned         col_pos = 0;
   int unsigned         row_pos = 0;

   // predictor copy of the registers
   logic [COEF_W-1:0]   wt_center = COEF_CENTER_RESET;
   logic [COEF_W-1:0]   wt_edge = COEF_EDGE_RESET;
   logic [COEF_W-1:0]   wt_corner = COEF_CORNER_RESET;
   logic [WIDTH_W-1:0]  frame_width = IMAGE_WIDTH_RESET;
   logic [HEIGHT_W-1:0] frame_height = IMAGE_HEIGHT_RESET;

   gaussian_blur_3x3 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blurred_value (rsp_blurred_value),
      .rsp_is_last       (rsp_is_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // effective row length, register value clamped between MIN_SIZE and the line store depth
   function automatic int unsigned clamp_width(logic [WIDTH_W-1:0] raw);
      if (raw < MIN_SIZE) return MIN_SIZE;
      if (raw > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
      return 32'(raw);
   endfunction

   // advance the predictor by one accepted pixel, queue its blur if interior
   function automatic void predict_blur(pixel_type px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     edges;
      int unsigned     corners;
      logic [63:0]     acc;
      logic [63:0]     scaled;
      blur_result_type res;

      w = clamp_width(frame_width);
      if (frame_height < MIN_SIZE) h = MIN_SIZE;
      else if (frame_height > MAX_HEIGHT) h = MAX_HEIGHT;
      else h = 32'(frame_height);

      // slide left, new column comes from the two stored rows and the input
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = older_row[col_pos];
      win[1][2] = newer_row[col_pos];
      win[2][2] = px;
      older_row[col_pos] = newer_row[col_pos];
      newer_row[col_pos] = px;

      // window complete once two rows and two columns are behind us
      if (row_pos >= 2 && col_pos >= 2) begin
         edges = int'(win[0][1]) + int'(win[1][0]) + int'(win[1][2]) + int'(win[2][1]);
         corners = int'(win[0][0]) + int'(win[0][2]) + int'(win[2][0]) + int'(win[2][2]);
         acc = 64'(wt_center) * 64'(win[1][1]) + 64'(wt_edge) * 64'(edges)
             + 64'(wt_corner) * 64'(corners);
         scaled = (acc + 64'd32768) >> FRAC_BITS;
         res.value = (scaled > 64'd255) ? PIXEL_MAX : scaled[PIXEL_W-1:0];
         res.last = (col_pos >= w - 1) && (row_pos >= h - 1);
         expected_blurs.push_back(res);
      end

      // at-or-beyond compares so a mid-frame shrink ends the row or frame
      if (col_pos >= w - 1) begin
         col_pos = 0;
         row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   // one register write, mirrored into the predictor copy
   task automatic write_register(csr_index_type idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_COEF_CENTER:  wt_center = data;
         CSR_COEF_EDGE:    wt_edge = data;
         CSR_COEF_CORNER:  wt_corner = data;
         CSR_IMAGE_WIDTH:  frame_width = data[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: frame_height = data[HEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   // all pixels sent, all blurs back, then let border pixels leave the pipe
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || expected_blurs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_pixels(int unsigned count, pixel_style_type style);
      pixel_type px;
      px = pixel_type'($urandom_range(255));
      repeat (count) begin
         case (style)
            PIX_EXTREME: px = $urandom_range(1) ? PIXEL_MAX : '0;
            PIX_SMOOTH:  px = px + pixel_type'($urandom_range(8)) - pixel_type'(4);
            default:     px = pixel_type'($urandom_range(255));
         endcase
         pending_pixels.push_back(px);
      end
   endtask

   // pixel driver: new transaction only when the slot is empty or draining
   always @(posedge clock) begin : pixel_driver
      if (reset) begin
         req_valid <= 1'b0;
         req_pixel <= '0;
      end else begin
         if (req_valid && req_ready) predict_blur(req_pixel);
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0
                && (steady_flow || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_valid <= 1'b1;
               req_pixel <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : blur_monitor
      blur_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_blurs.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual value %0d last %0b",
                        $time, rsp_blurred_value, rsp_is_last);
               mismatch_count++;
            end else begin
               want = expected_blurs.pop_front();
               if (rsp_blurred_value !== want.value) begin
                  $display("%0t: blurred_value mismatch, expected %0d, actual %0d",
                           $time, want.value, rsp_blurred_value);
                  mismatch_count++;
               end
               if (rsp_is_last !== want.last) begin
                  $display("%0t: is_last mismatch, expected %0b, actual %0b",
                           $time, want.last, rsp_is_last);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned      random_count;
      int unsigned      center_part;
      int unsigned      edge_part;
      logic [COEF_W-1:0] c_center;
      logic [COEF_W-1:0] c_edge;
      logic [COEF_W-1:0] c_corner;
      logic [CSR_W-1:0] size_word;
      pixel_style_type  style;

      random_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // smallest frame, reset weights, pixel values toggling every bit
      write_register(CSR_IMAGE_WIDTH, CSR_W'(MIN_SIZE));
      write_register(CSR_IMAGE_HEIGHT, CSR_W'(MIN_SIZE));
      foreach (pending_pixels[i]) ;
      pending_pixels.push_back(8'h00);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'h55);
      pending_pixels.push_back(8'hAA);
      pending_pixels.push_back(8'h01);
      pending_pixels.push_back(8'h80);
      pending_pixels.push_back(8'h7F);
      pending_pixels.push_back(8'hFE);
      pending_pixels.push_back(8'h0F);
      wait_idle();

      // sizes below the minimum clamp to 3x3, heavy weights saturate,
      // a write to an unused index must leave the width alone
      write_register(CSR_IMAGE_WIDTH, '0);
      write_register(CSR_IMAGE_HEIGHT, '0);
      write_register(CSR_COEF_CENTER, '1);
      write_register(CSR_COEF_EDGE, '1);
      write_register(CSR_COEF_CORNER, '0);
      write_register(csr_index_type'(CSR_INDEX_UNUSED), CSR_W'(8));
      queue_pixels(9, PIX_EXTREME);
      for (int i = 0; i < 9; i++) pending_pixels[i] = PIXEL_MAX;
      wait_idle();

      // widest line with all width bits set, no idling on either side,
      // stops early in the second row
      write_register(CSR_IMAGE_WIDTH, '1);
      write_register(CSR_IMAGE_HEIGHT, CSR_W'(MIN_SIZE));
      write_register(CSR_COEF_CENTER, COEF_CENTER_RESET);
      write_register(CSR_COEF_EDGE, COEF_EDGE_RESET);
      write_register(CSR_COEF_CORNER, COEF_CORNER_RESET);
      steady_flow <= 1'b1;
      queue_pixels(WIDE_PIXELS, PIX_UNIFORM);
      wait_idle();
      steady_flow <= 1'b0;

      // random phases, registers rewritten only while the pipe is empty
      while (random_count < RANDOM_PIXELS) begin
         if ($urandom_range(99) < 70) begin
            wait_idle();
            if ($urandom_range(99) < 50) begin
               case ($urandom_range(2))
                  0: begin
                     c_center = COEF_W'($urandom_range(16'hFFFF));
                     c_edge = COEF_W'($urandom_range(16'hFFFF));
                     c_corner = COEF_W'($urandom_range(16'hFFFF));
                  end
                  1: begin
                     c_center = $urandom_range(1) ? '1 : '0;
                     c_edge = $urandom_range(1) ? '1 : '0;
                     c_corner = $urandom_range(1) ? '1 : '0;
                  end
                  default: begin
                     // weights summing to about one, as software would load
                     center_part = $urandom_range(40960, 4096);
                     edge_part = $urandom_range((65536 - center_part) / 4);
                     c_center = COEF_W'(center_part);
                     c_edge = COEF_W'(edge_part);
                     c_corner = COEF_W'((65536 - center_part - 4 * edge_part) / 4);
                  end
               endcase
               write_register(CSR_COEF_CENTER, c_center);
               write_register(CSR_COEF_EDGE, c_edge);
               write_register(CSR_COEF_CORNER, c_corner);
            end
            if ($urandom_range(99) < 60) begin
               case ($urandom_range(9))
                  0:       size_word = CSR_W'($urandom_range(2));
                  1:       size_word = $urandom_range(1) ? CSR_W'(MAX_WIDTH_DEFAULT)
                                                        : CSR_W'($urandom_range(16'hFFFF));
                  default: size_word = CSR_W'($urandom_range(12, MIN_SIZE));
               endcase
               // grow only in the first row, so no result sees a stale store
               if (row_pos == 0
                   || clamp_width(size_word[WIDTH_W-1:0]) <= clamp_width(frame_width))
                  write_register(CSR_IMAGE_WIDTH, size_word);
            end
            if ($urandom_range(99) < 60) begin
               case ($urandom_range(9))
                  0:       size_word = CSR_W'($urandom_range(2));
                  1:       size_word = $urandom_range(1) ? CSR_W'(MAX_HEIGHT)
                                                        : CSR_W'($urandom_range(16'hFFFF));
                  2:       size_word = CSR_W'($urandom_range(20, 9));
                  default: size_word = CSR_W'($urandom_range(8, MIN_SIZE));
               endcase
               write_register(CSR_IMAGE_HEIGHT, size_word);
            end
         end
         case ($urandom_range(4))
            0:       style = PIX_EXTREME;
            1:       style = PIX_SMOOTH;
            default: style = PIX_UNIFORM;
         endcase
         center_part = $urandom_range(60, 1);
         queue_pixels(center_part, style);
         random_count += center_part;
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
sv/gb3_pkg.sv
sv/gb3_line_store.sv
sv/gb3_column_cell.sv
sv/gaussian_blur_3x3.sv
sim/gaussian_blur_3x3_tb.sv
